### rtl/wmf_pkg.sv
// Shared constants for the window median filter.
// No dependencies.
package wmf_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned CoordW = 9;
  localparam int unsigned SizeW  = 10;
  localparam int unsigned HalfW  = 2;
  localparam int unsigned CfgIdxW = 2;

  // input action codes
  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRows = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCols = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHalf = 2'd2;

  localparam logic [SizeW-1:0] RowsReset = 10'd512;
  localparam logic [SizeW-1:0] ColsReset = 10'd512;
  localparam logic [HalfW-1:0] HalfReset = 2'd1;

endpackage

### rtl/wmf_ram.sv
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module wmf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 262144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### rtl/wmf_sorter.sv
// Insertion sorter: a row of cells kept in ascending order, one insert a cycle.
// Depends on wmf_pkg.
module wmf_sorter
  import wmf_pkg::*;
#(
  parameter int unsigned NumCells = 49
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          insert_i,
  input  logic [PixW-1:0]               data_i,
  output logic [NumCells-1:0][PixW-1:0] cells_o
);

  logic [NumCells-1:0][PixW-1:0] val_q, val_d;
  logic [NumCells-1:0]           vld_q, vld_d;
  logic [NumCells-1:0]           le;

  // each cell keeps, takes the new value, or takes its lower neighbour
  always_comb begin
    for (int i = 0; i < NumCells; i++) begin
      le[i] = vld_q[i] && (val_q[i] <= data_i);
    end
    for (int i = 0; i < NumCells; i++) begin
      if (le[i]) begin
        val_d[i] = val_q[i];
      end else if (i == 0) begin
        val_d[i] = data_i;
      end else if (le[(i == 0) ? 0 : i-1]) begin
        val_d[i] = data_i;
      end else begin
        val_d[i] = val_q[(i == 0) ? 0 : i-1];
      end
      vld_d[i] = vld_q[i] || (i == 0) || vld_q[(i == 0) ? 0 : i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clear_i) begin
      vld_q <= '0;
    end else if (insert_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (insert_i) begin
      val_q <= val_d;
    end
  end

  assign cells_o = val_q;

  // occupied cells always form a block from cell 0 upwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_q >> 1) & ~vld_q) == '0)
    else $error("sorter occupancy not contiguous");

  // a clear empties every cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> (vld_q == '0))
    else $error("sorter not empty after clear");

  // an insert always occupies the bottom cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (insert_i && !clear_i) |=> vld_q[0])
    else $error("sorter bottom cell empty after insert");

endmodule

### rtl/window_median_filter_top.sv
// Top level of the window median filter: frame store, sequencer and sorter.
// Depends on wmf_pkg, wmf_ram and wmf_sorter.
//
// channel   direction  handshake                  payload
// in        in         in_valid_i / in_stall_o    action_i row_index_i col_index_i pixel_in_i
// out       out        out_valid_o / out_stall_i  pixel_out_o
// cfg       in         cfg_we_i                   cfg_index_i cfg_data_i
//
// A load passes through a calc and a write step (calc only outside the image);
// a query inside the window area reads the frame store once per window pixel
// (single RAM port), a border query reads only the centre pixel and an outside
// query returns 0. One item is worked on at a time.
// Reset clears control state only; the frame store is undefined until written.
// The result sits in an output register, so a stalled output does not block
// the next input transfer; only a second result waits for it.
module window_median_filter_top
  import wmf_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 512,
  parameter int unsigned MAX_COLS = 512,
  parameter int unsigned MAX_HALF = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [CoordW-1:0]  row_index_i,
  input  logic [CoordW-1:0]  col_index_i,
  input  logic [PixW-1:0]    pixel_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PixW-1:0]    pixel_out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SizeW-1:0]   cfg_data_i
);

  localparam int unsigned Depth    = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned NumCells = (2 * MAX_HALF + 1) * (2 * MAX_HALF + 1);
  localparam int unsigned EffHW    = $clog2(MAX_HALF + 1);
  localparam int unsigned SpanW    = EffHW + 1;
  localparam int unsigned CmpW     = 14;

  typedef enum logic [3:0] {
    StIdle, StCalc, StWrite, StOrigin, StRead, StDrain, StMedian,
    StCenter, StCwait, StFinish
  } state_e;

  state_e                 state_q;
  logic                   act_q;
  logic [CoordW-1:0]      row_q, col_q;
  logic [PixW-1:0]        pix_q, res_q, out_q;
  logic [AddrW-1:0]       addr_q;
  logic [SpanW-1:0]       dr_q, dc_q;
  logic                   rd_vld_q, out_vld_q;
  logic [SizeW-1:0]       rows_q, cols_q;
  logic [HalfW-1:0]       half_q;

  logic [CmpW-1:0]        rows_eff, cols_eff;
  logic [EffHW-1:0]       half_eff;
  logic [SpanW-1:0]       span;
  logic                   in_image, border;
  logic [PixW-1:0]        rdata, med;
  logic [NumCells-1:0][PixW-1:0] cells;
  logic                   in_xfer;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RowsReset;
      cols_q <= ColsReset;
      half_q <= HalfReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRows: rows_q <= cfg_data_i;
        CfgCols: cols_q <= cfg_data_i;
        CfgHalf: half_q <= cfg_data_i[HalfW-1:0];
        default: ;
      endcase
    end
  end

  // saturate to the built sizes
  always_comb begin
    rows_eff = (CmpW'(rows_q) > CmpW'(MAX_ROWS)) ? CmpW'(MAX_ROWS) : CmpW'(rows_q);
    cols_eff = (CmpW'(cols_q) > CmpW'(MAX_COLS)) ? CmpW'(MAX_COLS) : CmpW'(cols_q);
    half_eff = (CmpW'(half_q) > CmpW'(MAX_HALF)) ? EffHW'(MAX_HALF)
                                                  : EffHW'(half_q);
    span     = {half_eff, 1'b0};
  end

  // position checks on the captured coordinate
  always_comb begin
    in_image = (CmpW'(row_q) < rows_eff) && (CmpW'(col_q) < cols_eff);
    border   = (CmpW'(row_q) < CmpW'(half_eff))
            || (CmpW'(row_q) + CmpW'(half_eff) >= rows_eff)
            || (CmpW'(col_q) < CmpW'(half_eff))
            || (CmpW'(col_q) + CmpW'(half_eff) >= cols_eff);
  end

  // middle cell for each window size
  always_comb begin
    med = '0;
    for (int k = 0; k <= MAX_HALF; k++) begin
      if (half_eff == EffHW'(k)) begin
        med = cells[((2 * k + 1) * (2 * k + 1)) >> 1];
      end
    end
  end

  assign in_xfer = in_valid_i && !in_stall_o;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      dr_q      <= '0;
      dc_q      <= '0;
    end else begin
      rd_vld_q <= (state_q == StRead);
      // result register: filled from the finish step, emptied by a transfer
      if (state_q == StFinish && (!out_vld_q || !out_stall_i)) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_xfer) state_q <= StCalc;
        end
        StCalc: begin
          if (act_q == ActLoad) begin
            state_q <= in_image ? StWrite : StIdle;
          end else if (!in_image) begin
            state_q <= StFinish;
          end else if (border) begin
            state_q <= StCenter;
          end else begin
            state_q <= StOrigin;
          end
        end
        StWrite:  state_q <= StIdle;
        StOrigin: begin
          dr_q    <= '0;
          dc_q    <= '0;
          state_q <= StRead;
        end
        StRead: begin
          if (dc_q == span) begin
            dc_q <= '0;
            if (dr_q == span) begin
              state_q <= StDrain;
            end else begin
              dr_q <= dr_q + SpanW'(1);
            end
          end else begin
            dc_q <= dc_q + SpanW'(1);
          end
        end
        StDrain:  state_q <= StMedian;
        StMedian: state_q <= StFinish;
        StCenter: state_q <= StCwait;
        StCwait:  state_q <= StFinish;
        StFinish: begin
          if (!out_vld_q || !out_stall_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q <= action_i;
      row_q <= row_index_i;
      col_q <= col_index_i;
      pix_q <= pixel_in_i;
    end
    case (state_q)
      StCalc: begin
        addr_q <= AddrW'(row_q * AddrW'(MAX_COLS) + AddrW'(col_q));
        res_q  <= '0;
      end
      StOrigin: addr_q <= addr_q - AddrW'(half_eff * AddrW'(MAX_COLS))
                                 - AddrW'(half_eff);
      StRead: begin
        if (dc_q == span) begin
          addr_q <= addr_q + AddrW'(MAX_COLS) - AddrW'(span);
        end else begin
          addr_q <= addr_q + AddrW'(1);
        end
      end
      StMedian: res_q <= med;
      StCwait:  res_q <= rdata;
      StFinish: begin
        if (!out_vld_q || !out_stall_i) out_q <= res_q;
      end
      default: ;
    endcase
  end

  wmf_ram #(
    .Width(PixW),
    .Depth(Depth)
  ) u_frame_store (
    .clk_i  (clk_i),
    .we_i   (state_q == StWrite),
    .addr_i (addr_q),
    .wdata_i(pix_q),
    .rdata_o(rdata)
  );

  wmf_sorter #(
    .NumCells(NumCells)
  ) u_sorter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (state_q == StOrigin),
    .insert_i(rd_vld_q),
    .data_i  (rdata),
    .cells_o (cells)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_vld_q;
  assign pixel_out_o = out_q;

  // the store is only written for loads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |-> (act_q == ActLoad))
    else $error("frame store written during a query");

  // window counters stay within the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> (dr_q <= span) && (dc_q <= span))
    else $error("window counter overrun");

  // a new result appears only from the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == StFinish))
    else $error("result raised outside finish");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for window_median_filter_top: pixel loads and median
// queries are driven with random gaps, and results are checked against a predictor.
// Depends on wmf_pkg and window_median_filter_top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wmf_pkg::*;

  localparam int unsigned NRows = 512;
  localparam int unsigned NCols = 512;
  localparam int unsigned NHalf = 3;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic              act;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [PixW-1:0]   px;
  } pix_op_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               action = ActLoad;
  logic [CoordW-1:0]  row_index = '0;
  logic [CoordW-1:0]  col_index = '0;
  logic [PixW-1:0]    pixel_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PixW-1:0]    pixel_out;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgRows;
  logic [SizeW-1:0]   cfg_data = '0;

  window_median_filter_top #(
    .MAX_ROWS(NRows), .MAX_COLS(NCols), .MAX_HALF(NHalf)
  ) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .row_index_i(row_index), .col_index_i(col_index),
    .pixel_in_i(pixel_in),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .pixel_out_o(pixel_out),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // predictor state: register copies, frame copy, and which entries get written
  logic [SizeW-1:0] rows_reg = RowsReset;
  logic [SizeW-1:0] cols_reg = ColsReset;
  logic [HalfW-1:0] half_reg = HalfReset;
  logic [PixW-1:0]  frame_px [NRows*NCols];
  bit               px_loaded [NRows*NCols];

  pix_op_t          pixel_ops_q[$];
  logic [PixW-1:0]  median_q[$];
  int               n_err = 0;
  int               hold_asks = 0;
  int               drain_asks = 0;
  bit               no_idle = 1'b0;

  function automatic int eff_rows();
    return (rows_reg > NRows) ? NRows : int'(rows_reg);
  endfunction

  function automatic int eff_cols();
    return (cols_reg > NCols) ? NCols : int'(cols_reg);
  endfunction

  function automatic int eff_half();
    return (half_reg > NHalf) ? NHalf : int'(half_reg);
  endfunction

  function automatic bit near_edge(int r, int c);
    int h;
    h = eff_half();
    return (r < h) || (r + h >= eff_rows()) || (c < h) || (c + h >= eff_cols());
  endfunction

  // true when a query here reads only entries that are loaded by then
  function automatic bit query_safe(int r, int c);
    int h;
    h = eff_half();
    if (!(r < eff_rows() && c < eff_cols())) return 1'b1;
    if (near_edge(r, c)) return px_loaded[r*NCols + c];
    for (int i = r - h; i <= r + h; i++)
      for (int j = c - h; j <= c + h; j++)
        if (!px_loaded[i*NCols + j]) return 1'b0;
    return 1'b1;
  endfunction

  // median of the window, the pixel itself near an edge, 0 outside the image
  function automatic logic [PixW-1:0] filter_pixel(int r, int c);
    int h;
    int hist [256];
    int n;
    int acc;
    h = eff_half();
    if (!(r < eff_rows() && c < eff_cols())) return '0;
    if (near_edge(r, c)) return frame_px[r*NCols + c];
    foreach (hist[v]) hist[v] = 0;
    for (int i = r - h; i <= r + h; i++)
      for (int j = c - h; j <= c + h; j++)
        hist[frame_px[i*NCols + j]]++;
    n = (2*h + 1) * (2*h + 1);
    acc = 0;
    for (int v = 0; v < 256; v++) begin
      acc += hist[v];
      if (acc > n / 2) return PixW'(v);
    end
    return '1;
  endfunction

  // update the frame copy or queue the expected pixel for an accepted transfer
  function automatic void record_transfer(pix_op_t op);
    if (op.act == ActLoad) begin
      if (op.row < eff_rows() && op.col < eff_cols()) frame_px[op.row*NCols + op.col] = op.px;
    end else begin
      median_q.push_back(filter_pixel(op.row, op.col));
    end
  endfunction

  // queue an item; a query that could read an unloaded entry becomes a load
  function automatic void queue_op(logic act, int r, int c, int px);
    pix_op_t op;
    op.act = act;
    op.row = CoordW'(r);
    op.col = CoordW'(c);
    op.px  = PixW'(px);
    if (op.act == ActQuery && !query_safe(op.row, op.col)) op.act = ActLoad;
    if (op.act == ActLoad && op.row < eff_rows() && op.col < eff_cols())
      px_loaded[op.row*NCols + op.col] = 1'b1;
    pixel_ops_q.push_back(op);
  endfunction

  function automatic int rand_px();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 0;
    if (k == 1) return 255;
    return $urandom_range(255);
  endfunction

  // input driver: one transfer at a time, random gaps, optional drain pauses
  always @(posedge clk_i) begin : driver
    pix_op_t     cur;
    logic        nxt_valid;
    int          gap;
    int          drain_done;
    bit          self_drain;
    int          k;
    if (!rst_ni) begin
      gap = 0;
      drain_done = 0;
      self_drain = 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) record_transfer(cur);
      nxt_valid = 1'b0;
      if (drain_done != drain_asks || self_drain) begin
        if (median_q.size() == 0) begin
          if (drain_done != drain_asks) drain_done++;
          self_drain = 1'b0;
        end
      end else if (gap > 0) begin
        gap--;
      end else if (pixel_ops_q.size() > 0) begin
        cur = pixel_ops_q.pop_front();
        nxt_valid = 1'b1;
        k = $urandom_range(99);
        if (no_idle || k < 60) gap = 0;
        else if (k < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if ($urandom_range(79) == 0) self_drain = 1'b1;
      end
      in_valid <= nxt_valid;
      if (nxt_valid) begin
        action    <= cur.act;
        row_index <= cur.row;
        col_index <= cur.col;
        pixel_in  <= cur.px;
      end
    end
  end

  // output stall: random short and long stalls, plus requested long hold-offs
  always @(posedge clk_i) begin : stall_gen
    int hold_done;
    int hold_left;
    int stall_left;
    int k;
    logic st;
    if (!rst_ni) begin
      hold_done = 0;
      hold_left = 0;
      stall_left = 0;
    end else begin
      if (hold_done != hold_asks) begin
        hold_done++;
        hold_left = 1500;
      end
      st = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        st = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        st = 1'b1;
      end else if (!no_idle) begin
        k = $urandom_range(99);
        if (k >= 95) stall_left = $urandom_range(10, 50);
        else if (k >= 70) stall_left = $urandom_range(1, 3);
      end
      out_stall <= st;
    end
  end

  // result checker
  always @(posedge clk_i) begin : result_check
    logic [PixW-1:0] exp_px;
    if (rst_ni && out_valid && !out_stall) begin
      if (median_q.size() == 0) begin
        n_err++;
        $display("%t: unexpected result transfer, pixel_out %0d", $realtime, pixel_out);
      end else begin
        exp_px = median_q.pop_front();
        if (pixel_out !== exp_px) begin
          n_err++;
          $display("%t: pixel_out mismatch, expected %0d, actual %0d",
                   $realtime, exp_px, pixel_out);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin : watchdog
    int cycles;
    if (!rst_ni) cycles = 0;
    else begin
      cycles++;
      if (cycles > CycleLimit) begin
        $display("window_median_filter_top regression: fail");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pixel_ops_q.size() != 0 || in_valid || median_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= SizeW'(val);
    case (idx)
      CfgRows: rows_reg = SizeW'(val);
      CfgCols: cols_reg = SizeW'(val);
      default: half_reg = HalfW'(val);
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // one setting: load a block of the image, then random loads and queries
  task automatic run_phase(int rows, int cols, int half, int n_ops);
    int er, ec, bh, bw, r0, c0, r, c;
    wait_idle();
    write_reg(CfgRows, rows);
    write_reg(CfgCols, cols);
    write_reg(CfgHalf, half);
    er = eff_rows();
    ec = eff_cols();
    bh = (er < 2*eff_half() + 2) ? er : 2*eff_half() + 2;
    bw = (ec < 2*eff_half() + 2) ? ec : 2*eff_half() + 2;
    r0 = (er > bh) ? $urandom_range(er - bh) : 0;
    c0 = (ec > bw) ? $urandom_range(ec - bw) : 0;
    for (int i = 0; i < bh; i++)
      for (int j = 0; j < bw; j++)
        queue_op(ActLoad, r0 + i, c0 + j, rand_px());
    for (int n = 0; n < n_ops; n++) begin
      if ($urandom_range(4) != 0) begin
        r = (r0 - 1 + $urandom_range(bh + 1)) & 9'h1FF;
        c = (c0 - 1 + $urandom_range(bw + 1)) & 9'h1FF;
      end else begin
        r = $urandom_range(511);
        c = $urandom_range(511);
      end
      queue_op(($urandom_range(99) < 65) ? ActQuery : ActLoad, r, c, rand_px());
    end
  endtask

  // stimulus
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corners, value extremes, one median at reset settings
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        queue_op(ActLoad, i, j, (i*3 + j) % 2 ? 255 : (i*3 + j) * 20);
    queue_op(ActLoad, 511, 511, 255);
    queue_op(ActLoad, 0, 511, 0);
    queue_op(ActLoad, 511, 0, 128);
    queue_op(ActQuery, 1, 1, 255);
    queue_op(ActQuery, 0, 0, 0);
    queue_op(ActQuery, 511, 511, 0);
    queue_op(ActQuery, 0, 511, 0);
    queue_op(ActQuery, 511, 0, 0);
    queue_op(ActQuery, 1, 0, 0);

    run_phase(4, 5, 0, 12);
    run_phase(0, 7, 1, 8);
    run_phase(7, 0, 2, 8);
    run_phase(1, 1, 3, 8);
    run_phase(3, 3, 1, 12);
    run_phase(8, 8, 3, 15);
    drain_asks++;
    run_phase(1023, 1023, 2, 20);
    no_idle = 1'b1;
    hold_asks++;
    run_phase(512, 512, 3, 40);
    wait_idle();
    no_idle = 1'b0;
    run_phase(6, 512, 2, 15);
    run_phase(512, 9, 3, 15);
    run_phase(20, 30, 1, 20);
    run_phase(2, 9, 0, 12);
    run_phase(7, 7, 3, 15);
    run_phase(512, 512, 0, 15);

    wait_idle();
    if (n_err == 0) begin
      $display("window_median_filter_top regression: pass");
    end else begin
      $display("window_median_filter_top regression: fail");
    end
    $finish;
  end

endmodule
